### rtl/core/sscp_pkg.sv
// Shared types and constants for the segment closest points core.
`timescale 1ns / 1ps
package sscp_pkg;
   localparam int CoordBits = 16;
   localparam int FracBits  = 16;
   localparam int ParamBits = FracBits + 1;
   localparam int PointBits = CoordBits + FracBits;
   localparam int DistBits  = 2 * CoordBits + 2 + FracBits;
   localparam int DiffBits  = CoordBits + 1;
   localparam int DotBits   = 2 * DiffBits + 2;
   localparam int WideBits  = 2 * DotBits + 2;
   localparam int ProdBits  = 2 * (PointBits + 2);

   typedef struct packed {
      logic signed [CoordBits-1:0] p0_x;
      logic signed [CoordBits-1:0] p0_y;
      logic signed [CoordBits-1:0] p0_z;
      logic signed [CoordBits-1:0] p1_x;
      logic signed [CoordBits-1:0] p1_y;
      logic signed [CoordBits-1:0] p1_z;
      logic signed [CoordBits-1:0] q0_x;
      logic signed [CoordBits-1:0] q0_y;
      logic signed [CoordBits-1:0] q0_z;
      logic signed [CoordBits-1:0] q1_x;
      logic signed [CoordBits-1:0] q1_y;
      logic signed [CoordBits-1:0] q1_z;
   } req_word_type;

   typedef struct packed {
      logic [ParamBits-1:0]        s_param;
      logic [ParamBits-1:0]        t_param;
      logic signed [PointBits-1:0] c1_x;
      logic signed [PointBits-1:0] c1_y;
      logic signed [PointBits-1:0] c1_z;
      logic signed [PointBits-1:0] c2_x;
      logic signed [PointBits-1:0] c2_y;
      logic signed [PointBits-1:0] c2_z;
      logic [DistBits-1:0]         dist_sq;
   } rsp_word_type;

   localparam logic [0:0] RegDegenerateLimit = 1'b0;
endpackage

### rtl/core/segment_segment_closest_points_core.sv
// Top level: closest points between two 3D segments, fully pipelined.
// The path from the accepting edge to rsp_valid holds two divider passes of 17 stages.
// Throughput: one word per cycle; busy is always low.
// The receiver cannot stall; rsp_valid pulses for one cycle per word.
// Synchronous reset clears all valid bits and sets degenerate_limit to 0.
`timescale 1ns / 1ps
module segment_segment_closest_points_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sscp_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output sscp_pkg::rsp_word_type rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   localparam int CB = sscp_pkg::CoordBits;
   localparam int FB = sscp_pkg::FracBits;
   localparam int PB = sscp_pkg::ParamBits;
   localparam int DB = sscp_pkg::DiffBits;
   localparam int OB = sscp_pkg::DotBits;
   localparam int WB = sscp_pkg::WideBits;
   localparam int Steps = FB + 1;
   // carried context per item: p0,q0,d1,d2, a,b,c,e,f, flags
   localparam int CtxBits = 6 * CB + 6 * DB + 5 * OB + 2;

   // how the second divider result is used
   localparam logic [1:0] ModeRatioT = 2'd0;  // keep s, t from the divider
   localparam logic [1:0] ModeZeroT  = 2'd1;  // t = 0, s from the divider
   localparam logic [1:0] ModeOneT   = 2'd2;  // t = 1, s from the divider
   localparam logic [1:0] ModeFixed  = 2'd3;  // s and t already known

   logic [15:0] limit_ff;
   assign pready = 1'b1;
   assign busy   = 1'b0;
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (psel && penable && pwrite &&
                   paddr[2] == sscp_pkg::RegDegenerateLimit) begin
         limit_ff <= pwdata[15:0];
      end
   end
   assign prdata = (paddr[2] == sscp_pkg::RegDegenerateLimit) ? {16'd0, limit_ff} : '0;

   // ---- stage 1: differences
   logic v1_ff;
   logic signed [CB-1:0] p0_ff [3], q0_ff [3];
   logic signed [DB-1:0] d1_ff [3], d2_ff [3], r_ff [3];
   logic signed [CB-1:0] ip0 [3], ip1 [3], iq0 [3], iq1 [3];
   assign ip0 = '{req_word.p0_x, req_word.p0_y, req_word.p0_z};
   assign ip1 = '{req_word.p1_x, req_word.p1_y, req_word.p1_z};
   assign iq0 = '{req_word.q0_x, req_word.q0_y, req_word.q0_z};
   assign iq1 = '{req_word.q1_x, req_word.q1_y, req_word.q1_z};
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         p0_ff[k] <= ip0[k];
         q0_ff[k] <= iq0[k];
         d1_ff[k] <= DB'(ip1[k]) - DB'(ip0[k]);
         d2_ff[k] <= DB'(iq1[k]) - DB'(iq0[k]);
         r_ff[k]  <= DB'(ip0[k]) - DB'(iq0[k]);
      end
   end

   // ---- stage 2: products; stage 3: dot sums
   logic v2_ff, v3_ff;
   logic signed [2*DB-1:0] pa_ff [3], pe_ff [3], pbb_ff [3], pc_ff [3], pf_ff [3];
   logic signed [CB-1:0] p0b_ff [3], q0b_ff [3];
   logic signed [DB-1:0] d1b_ff [3], d2b_ff [3];
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         pa_ff[k]  <= d1_ff[k] * d1_ff[k];
         pe_ff[k]  <= d2_ff[k] * d2_ff[k];
         pbb_ff[k] <= d1_ff[k] * d2_ff[k];
         pc_ff[k]  <= d1_ff[k] * r_ff[k];
         pf_ff[k]  <= d2_ff[k] * r_ff[k];
         p0b_ff[k] <= p0_ff[k];
         q0b_ff[k] <= q0_ff[k];
         d1b_ff[k] <= d1_ff[k];
         d2b_ff[k] <= d2_ff[k];
      end
   end

   logic signed [OB-1:0] a_ff, b_ff, c_ff, e_ff, f_ff;
   logic signed [CB-1:0] p0c_ff [3], q0c_ff [3];
   logic signed [DB-1:0] d1c_ff [3], d2c_ff [3];
   always_ff @(posedge clock) begin
      a_ff <= OB'(pa_ff[0]) + OB'(pa_ff[1]) + OB'(pa_ff[2]);
      e_ff <= OB'(pe_ff[0]) + OB'(pe_ff[1]) + OB'(pe_ff[2]);
      b_ff <= OB'(pbb_ff[0]) + OB'(pbb_ff[1]) + OB'(pbb_ff[2]);
      c_ff <= OB'(pc_ff[0]) + OB'(pc_ff[1]) + OB'(pc_ff[2]);
      f_ff <= OB'(pf_ff[0]) + OB'(pf_ff[1]) + OB'(pf_ff[2]);
      p0c_ff <= p0b_ff; q0c_ff <= q0b_ff; d1c_ff <= d1b_ff; d2c_ff <= d2b_ff;
   end

   // ---- stage 4: cross products and degenerate flags
   logic v4_ff;
   logic signed [WB-1:0] ae_ff, bb_ff, bf_ff, ce_ff;
   logic signed [OB-1:0] a4_ff, b4_ff, c4_ff, e4_ff, f4_ff;
   logic deg_a_ff, deg_e_ff;
   logic [6*CB+6*DB-1:0] geo4_ff;
   always_ff @(posedge clock) begin
      ae_ff <= WB'(a_ff * e_ff);
      bb_ff <= WB'(b_ff * b_ff);
      bf_ff <= WB'(b_ff * f_ff);
      ce_ff <= WB'(c_ff * e_ff);
      a4_ff <= a_ff; b4_ff <= b_ff; c4_ff <= c_ff; e4_ff <= e_ff; f4_ff <= f_ff;
      deg_a_ff <= a_ff <= OB'(limit_ff);
      deg_e_ff <= e_ff <= OB'(limit_ff);
      geo4_ff <= {p0c_ff[0], p0c_ff[1], p0c_ff[2], q0c_ff[0], q0c_ff[1], q0c_ff[2],
                  d1c_ff[0], d1c_ff[1], d1c_ff[2], d2c_ff[0], d2c_ff[1], d2c_ff[2]};
   end

   // ---- stage 5: denom and numerator of s (or the degenerate ratio)
   logic v5_ff;
   logic signed [WB-1:0] n5_ff;
   logic [WB-1:0] d5_ff;
   logic [CtxBits-1:0] ctx5_ff;
   always_ff @(posedge clock) begin
      logic signed [WB-1:0] den;
      den = ae_ff - bb_ff;
      ctx5_ff <= {geo4_ff, a4_ff, b4_ff, c4_ff, e4_ff, f4_ff, deg_a_ff, deg_e_ff};
      if (deg_a_ff) begin
         n5_ff <= '0; d5_ff <= WB'(1);
      end else if (deg_e_ff || den == '0) begin
         n5_ff <= deg_e_ff ? -WB'(c4_ff) : '0;
         d5_ff <= deg_e_ff ? WB'(a4_ff) : WB'(1);
      end else begin
         n5_ff <= bf_ff - ce_ff;
         d5_ff <= den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff} <= '0;
      end else begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff} <= {start, v1_ff, v2_ff, v3_ff, v4_ff};
      end
   end

   // context delay line alongside the first divider
   logic [Steps-1:0][CtxBits-1:0] ctxa_ff;
   always_ff @(posedge clock) begin
      ctxa_ff <= {ctxa_ff[Steps-2:0], ctx5_ff};
   end

   logic v6; logic [PB-1:0] s1;
   sscp_ratio u_div_s (
      .clock(clock), .reset(reset), .in_valid(v5_ff), .in_num(n5_ff), .in_den(d5_ff),
      .out_valid(v6), .out_q(s1));

   logic signed [OB-1:0] cb;
   assign cb = $signed(ctxa_ff[Steps-1][2+3*OB +: OB]);

   // ---- stage 7: tn = b*s + f*one
   logic v7_ff, v8_ff;
   logic signed [WB-1:0] bs_ff, tn_ff;
   logic [PB-1:0] s7_ff, s8_ff;
   logic [CtxBits-1:0] ctx7_ff, ctx8_ff;
   always_ff @(posedge clock) begin
      bs_ff   <= WB'(cb * $signed({1'b0, s1}));
      s7_ff   <= s1;
      ctx7_ff <= ctxa_ff[Steps-1];
      s8_ff   <= s7_ff;
      ctx8_ff <= ctx7_ff;
      tn_ff   <= bs_ff + (WB'($signed(ctx7_ff[2 +: OB])) <<< FB);
   end

   // ---- stage 9: choose second ratio pair (t or recomputed s)
   logic v9_ff;
   logic signed [WB-1:0] n9_ff;
   logic [WB-1:0] d9_ff;
   logic [1:0] mode9_ff;
   logic [PB-1:0] s9_ff, t9_ff;
   logic [CtxBits-1:0] ctx9_ff;
   always_ff @(posedge clock) begin
      logic signed [OB-1:0] a8, b8, c8, e8, f8;
      logic da8, de8;
      logic signed [WB-1:0] ew;
      {a8, b8, c8, e8, f8, da8, de8} = ctx8_ff[5*OB+1:0];
      ew = WB'(e8) <<< FB;
      ctx9_ff <= ctx8_ff;
      s9_ff <= s8_ff;
      t9_ff <= '0;
      mode9_ff <= ModeFixed;
      n9_ff <= '0; d9_ff <= WB'(1);
      if (da8 && de8) begin
         s9_ff <= '0;
      end else if (da8) begin
         mode9_ff <= ModeRatioT; s9_ff <= '0; n9_ff <= WB'(f8); d9_ff <= WB'(e8);
      end else if (de8) begin
         s9_ff <= s8_ff;
      end else if (tn_ff < 0) begin
         mode9_ff <= ModeZeroT; n9_ff <= -WB'(c8); d9_ff <= WB'(a8);
      end else if (tn_ff > ew) begin
         mode9_ff <= ModeOneT; t9_ff <= PB'(1) << FB;
         n9_ff <= WB'(b8) - WB'(c8); d9_ff <= WB'(a8);
      end else begin
         mode9_ff <= ModeRatioT; n9_ff <= tn_ff; d9_ff <= ew;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) {v7_ff, v8_ff, v9_ff} <= '0;
      else {v7_ff, v8_ff, v9_ff} <= {v6, v7_ff, v8_ff};
   end

   localparam int TB = CtxBits + 2 + 2 * PB;
   logic [Steps-1:0][TB-1:0] ctxb_ff;
   always_ff @(posedge clock) begin
      ctxb_ff <= {ctxb_ff[Steps-2:0], {ctx9_ff, mode9_ff, s9_ff, t9_ff}};
   end
   logic v10; logic [PB-1:0] q2;
   sscp_ratio u_div_t (
      .clock(clock), .reset(reset), .in_valid(v9_ff), .in_num(n9_ff), .in_den(d9_ff),
      .out_valid(v10), .out_q(q2));

   logic [CtxBits-1:0] ctxz; logic [1:0] modez; logic [PB-1:0] sz, tz;
   assign {ctxz, modez, sz, tz} = ctxb_ff[Steps-1];

   // ---- stage 11: final s,t; stage 12: points; stage 13: differences; stage 14: squares; stage 15: sum
   logic v11_ff, v12_ff, v13_ff, v14_ff;
   logic [PB-1:0] s11_ff, t11_ff, s12_ff, t12_ff, s13_ff, t13_ff, s14_ff, t14_ff;
   logic [6*CB+6*DB-1:0] g11_ff;
   always_ff @(posedge clock) begin
      g11_ff <= ctxz[CtxBits-1 -: 6*CB+6*DB];
      case (modez)
         ModeRatioT: begin s11_ff <= sz; t11_ff <= q2; end
         ModeZeroT: begin s11_ff <= q2; t11_ff <= '0; end
         ModeOneT: begin s11_ff <= q2; t11_ff <= tz; end
         default: begin s11_ff <= sz; t11_ff <= tz; end
      endcase
   end

   localparam int PtB = sscp_pkg::PointBits;
   logic signed [PtB+1:0] c1_ff [3], c2_ff [3];
   logic signed [PtB+1:0] df_ff [3];
   logic signed [PtB-1:0] c1b_ff [3], c2b_ff [3], c1c_ff [3], c2c_ff [3];
   logic [sscp_pkg::ProdBits-1:0] sq_ff [3];
   logic [sscp_pkg::DistBits-1:0] dist_ff;
   logic signed [PtB-1:0] c1d_ff [3], c2d_ff [3];
   always_ff @(posedge clock) begin
      logic signed [CB-1:0] gp0 [3], gq0 [3];
      logic signed [DB-1:0] gd1 [3], gd2 [3];
      logic [sscp_pkg::ProdBits+1:0] sum;
      {gp0[0], gp0[1], gp0[2], gq0[0], gq0[1], gq0[2],
       gd1[0], gd1[1], gd1[2], gd2[0], gd2[1], gd2[2]} = g11_ff;
      for (int k = 0; k < 3; k++) begin
         c1_ff[k] <= ((PtB+2)'(gp0[k]) <<< FB) + (PtB+2)'(gd1[k] * $signed({1'b0, s11_ff}));
         c2_ff[k] <= ((PtB+2)'(gq0[k]) <<< FB) + (PtB+2)'(gd2[k] * $signed({1'b0, t11_ff}));
         df_ff[k] <= c1_ff[k] - c2_ff[k];
         c1b_ff[k] <= PtB'(c1_ff[k]);
         c2b_ff[k] <= PtB'(c2_ff[k]);
         sq_ff[k] <= sscp_pkg::ProdBits'(df_ff[k] * df_ff[k]);
         c1c_ff[k] <= c1b_ff[k];
         c2c_ff[k] <= c2b_ff[k];
         c1d_ff[k] <= c1c_ff[k];
         c2d_ff[k] <= c2c_ff[k];
      end
      sum = (sscp_pkg::ProdBits+2)'(sq_ff[0]) + (sscp_pkg::ProdBits+2)'(sq_ff[1])
          + (sscp_pkg::ProdBits+2)'(sq_ff[2]);
      dist_ff <= sscp_pkg::DistBits'(sum >> FB);
      s12_ff <= s11_ff; t12_ff <= t11_ff;
      s13_ff <= s12_ff; t13_ff <= t12_ff;
      s14_ff <= s13_ff; t14_ff <= t13_ff;
   end
   logic v15_ff;
   always_ff @(posedge clock) begin
      if (reset) {v11_ff, v12_ff, v13_ff, v14_ff, v15_ff} <= '0;
      else {v11_ff, v12_ff, v13_ff, v14_ff, v15_ff} <= {v10, v11_ff, v12_ff, v13_ff, v14_ff};
   end
   logic [PB-1:0] s15_ff, t15_ff;
   always_ff @(posedge clock) begin
      s15_ff <= s14_ff; t15_ff <= t14_ff;
   end

   assign rsp_valid = v15_ff;
   assign rsp_word.s_param = s15_ff;
   assign rsp_word.t_param = t15_ff;
   assign rsp_word.c1_x = c1d_ff[0];
   assign rsp_word.c1_y = c1d_ff[1];
   assign rsp_word.c1_z = c1d_ff[2];
   assign rsp_word.c2_x = c2d_ff[0];
   assign rsp_word.c2_y = c2d_ff[1];
   assign rsp_word.c2_z = c2d_ff[2];
   assign rsp_word.dist_sq = dist_ff;
endmodule

### rtl/core/sscp_ratio.sv
// Pipelined restoring divider: num/den clamped to 0..1, one quotient bit per stage.
`timescale 1ns / 1ps
module sscp_ratio (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic signed [sscp_pkg::WideBits-1:0]   in_num,
   input  logic        [sscp_pkg::WideBits-1:0]   in_den,
   output logic                                   out_valid,
   output logic [sscp_pkg::ParamBits-1:0]         out_q
);
   localparam int Width = sscp_pkg::WideBits;
   localparam int Steps = sscp_pkg::FracBits;

   logic [Steps:0]                    vld_ff;
   logic [Steps:0][Width:0]           rem_ff;
   logic [Steps:0][Width-1:0]         den_ff;
   logic [Steps:0][sscp_pkg::ParamBits-1:0] q_ff;
   logic [Steps:0]                    fix_ff;

   logic [Width:0] num_u;
   assign num_u = {1'b0, in_num[Width-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[Steps-1:0], in_valid};
      end
   end

   // stage 0 decides the clamps; later stages shift and subtract
   always_ff @(posedge clock) begin
      logic [Width:0] sh;
      den_ff[0] <= in_den;
      rem_ff[0] <= num_u;
      fix_ff[0] <= 1'b0;
      q_ff[0]   <= '0;
      if (in_num[Width-1] || in_num == '0) begin
         fix_ff[0] <= 1'b1;
      end else if (num_u >= {1'b0, in_den}) begin
         fix_ff[0] <= 1'b1;
         q_ff[0]   <= sscp_pkg::ParamBits'(1) << Steps;
      end
      for (int i = 1; i <= Steps; i++) begin
         sh = rem_ff[i-1] << 1;
         den_ff[i] <= den_ff[i-1];
         fix_ff[i] <= fix_ff[i-1];
         if (fix_ff[i-1]) begin
            rem_ff[i] <= rem_ff[i-1];
            q_ff[i]   <= q_ff[i-1];
         end else if (sh >= {1'b0, den_ff[i-1]}) begin
            rem_ff[i] <= sh - {1'b0, den_ff[i-1]};
            q_ff[i]   <= {q_ff[i-1][sscp_pkg::ParamBits-2:0], 1'b1};
         end else begin
            rem_ff[i] <= sh;
            q_ff[i]   <= {q_ff[i-1][sscp_pkg::ParamBits-2:0], 1'b0};
         end
      end
   end

   assign out_valid = vld_ff[Steps];
   assign out_q     = q_ff[Steps];
endmodule

### rtl/core/sscp_checker.sv
// Port-level checker for the closest points core, with its bind.
`timescale 1ns / 1ps
module sscp_assertions (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input sscp_pkg::rsp_word_type rsp_word,
   input logic pready
);
   a_no_busy: assert property (@(posedge clock) busy == 1'b0) else $error("busy high");
   a_ready: assert property (@(posedge clock) pready) else $error("pready low");
   a_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result right after reset");
   a_s_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.s_param <= (sscp_pkg::ParamBits'(1) << sscp_pkg::FracBits))
      else $error("s out of range");
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.t_param <= (sscp_pkg::ParamBits'(1) << sscp_pkg::FracBits))
      else $error("t out of range");
endmodule

bind segment_segment_closest_points_core sscp_assertions u_sscp_assertions (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_word(rsp_word), .pready(pready));
